### rtl/slot_motor_limit_sequencer_top_macros.svh
// Assertion macros for the slot motor limit sequencer checker.
// Needs clk and rst_n in scope where a macro is used.
`ifndef SLOT_MOTOR_LIMIT_SEQUENCER_TOP_MACROS_SVH
`define SLOT_MOTOR_LIMIT_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication.
`define SMLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/smls_pkg.sv
// Shared types, codes and sizes for the slot motor limit sequencer.
// No dependencies.
package smls_pkg;

    localparam int ROWS   = 10;
    localparam int COLS   = 10;
    localparam int LINE_W = 10;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int CNT_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] SETTLE_RESET  = CNT_W'(500);
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(4000);

    typedef enum logic {
        FN_TICK  = 1'b0,
        FN_START = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RUN     = 3'd1,
        PH_TIMEOUT = 3'd2,
        PH_LIMERR  = 3'd3,
        PH_PREP    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        PL_LOW     = 2'd0,
        PL_HIGH    = 2'd1,
        PL_UNKNOWN = 2'd2
    } prior_t;

    typedef enum logic [1:0] {
        AL_NONE     = 2'd0,
        AL_CHANNEL  = 2'd1,
        AL_CONFLICT = 2'd2
    } alarm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE  = 2'd0,
        REG_TIMEOUT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        phase_t             phase;
        logic [ROW_W-1:0]   active_row;
        logic [COL_W-1:0]   active_col;
        logic [CNT_W-1:0]   settle_count;
        logic               settle_armed;
        logic [CNT_W-1:0]   timeout_count;
        logic               timeout_armed;
        prior_t             prior_limit;
    } seq_state_t;

    typedef struct packed {
        logic [LINE_W-1:0]  row_drive;
        logic [LINE_W-1:0]  col_drive;
        phase_t             motor_status;
        logic               start_accepted;
        alarm_t             alarm;
    } result_t;

endpackage

### rtl/smls_ctrl.sv
// Sequencer state register and per-beat next-state / result logic.
// Depends on smls_pkg.
module smls_ctrl
    import smls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                func,
    input  logic [ROW_W-1:0]    row,
    input  logic [COL_W-1:0]    col,
    input  logic [LINE_W-1:0]   limit_lines,
    input  logic [CNT_W-1:0]    settle_delay,
    input  logic [CNT_W-1:0]    run_timeout,
    output result_t             result
);

    seq_state_t st_reg;
    seq_state_t st_next;

    logic [LINE_W-1:0] lines_sh;
    logic              lim_cur;
    logic              settle_fired;

    function automatic seq_state_t stop_motor(input seq_state_t s, input phase_t ph);
        seq_state_t r;
        r               = s;
        r.active_row    = '0;
        r.active_col    = '0;
        r.settle_armed  = 1'b0;
        r.settle_count  = '0;
        r.timeout_armed = 1'b0;
        r.timeout_count = '0;
        r.prior_limit   = PL_UNKNOWN;
        r.phase         = ph;
        return r;
    endfunction

    always_comb
    begin
        st_next               = st_reg;
        result.start_accepted = 1'b0;
        result.alarm          = AL_NONE;
        settle_fired          = 1'b0;
        lines_sh              = limit_lines >> st_reg.active_row;
        lim_cur               = lines_sh[0];

        if (func == FN_START)
        begin
            if (row >= ROW_W'(ROWS) || col >= COL_W'(COLS))
            begin
                result.alarm = AL_CHANNEL;
            end
            else if (st_reg.phase == PH_RUN || st_reg.phase == PH_PREP)
            begin
                result.alarm = AL_CONFLICT;
            end
            else
            begin
                st_next.active_row    = row;
                st_next.active_col    = col;
                st_next.phase         = PH_PREP;
                st_next.settle_count  = settle_delay;
                st_next.settle_armed  = 1'b1;
                st_next.timeout_armed = 1'b0;
                st_next.timeout_count = '0;
                st_next.prior_limit   = PL_UNKNOWN;
                result.start_accepted = 1'b1;
            end
        end
        else
        begin
            if (st_reg.settle_armed)
            begin
                if (st_reg.settle_count <= CNT_W'(1))
                begin
                    settle_fired         = 1'b1;
                    st_next.settle_count = '0;
                    st_next.settle_armed = 1'b0;
                    if (lim_cur)
                    begin
                        st_next.phase         = PH_RUN;
                        st_next.timeout_count = run_timeout;
                        st_next.timeout_armed = 1'b1;
                        st_next.prior_limit   = PL_UNKNOWN;
                    end
                    else
                    begin
                        st_next = stop_motor(st_next, PH_LIMERR);
                    end
                end
                else
                begin
                    st_next.settle_count = st_reg.settle_count - CNT_W'(1);
                end
            end

            if (!settle_fired)
            begin
                if (st_next.phase == PH_RUN)
                begin
                    // edge stop needs a seen low, then a high
                    if (st_next.prior_limit == PL_LOW && lim_cur)
                        st_next = stop_motor(st_next, PH_IDLE);
                    else
                        st_next.prior_limit = lim_cur ? PL_HIGH : PL_LOW;
                end
                if (st_next.timeout_armed)
                begin
                    if (st_next.timeout_count <= CNT_W'(1))
                    begin
                        st_next      = stop_motor(st_next, PH_TIMEOUT);
                        result.alarm = AL_CHANNEL;
                    end
                    else
                    begin
                        st_next.timeout_count = st_next.timeout_count - CNT_W'(1);
                    end
                end
            end
        end

        result.motor_status = st_next.phase;
        result.row_drive    = '0;
        result.col_drive    = '0;
        if (st_next.phase == PH_PREP || st_next.phase == PH_RUN)
            result.row_drive = LINE_W'(1) << st_next.active_row;
        if (st_next.phase == PH_RUN)
            result.col_drive = LINE_W'(1) << st_next.active_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase         <= PH_IDLE;
            st_reg.active_row    <= '0;
            st_reg.active_col    <= '0;
            st_reg.settle_count  <= '0;
            st_reg.settle_armed  <= 1'b0;
            st_reg.timeout_count <= '0;
            st_reg.timeout_armed <= 1'b0;
            st_reg.prior_limit   <= PL_UNKNOWN;
        end
        else if (step)
        begin
            st_reg <= st_next;
        end
    end

endmodule

### rtl/slot_motor_limit_sequencer_top.sv
// Top level of the slot motor limit sequencer: config registers, beat handshake, result register.
// Depends on smls_pkg and smls_ctrl.
//
// Slot motor limit sequencer. Each input beat is either a one-millisecond tick (func 0) or a
// start request for one row/column motor (func 1), and every beat yields exactly one result
// beat carrying the row and column drive lines, the motor status, a start-taken flag and the
// alarm raised by that beat. A start checks the channel first (row or column out of range:
// alarm 1), then the busy state (prepare or running: alarm 2); otherwise it energises the row
// line and loads the settle delay. When the delay runs out the row's limit switch is sampled:
// active means the column line is energised and the run timeout loads, inactive means a stop
// with limit error. While running, a low-then-high on the row's limit switch stops the motor
// back to idle; timeout expiry stops it with status timeout and alarm 1. A delay or timeout of
// zero expires on the first tick, as one does. Throughput is one beat per clock: the state
// update for a beat is a single pass of logic into the state and result registers, and the
// only thing that holds the input off is a result beat left sitting in the result register
// while the output side stalls. The registered result beat shows in the cycle after its input.
// Configuration writes (index 0 settle delay, index 1 run timeout, higher indexes ignored) are
// always ready and are meant to be made while no beat is in flight.
module slot_motor_limit_sequencer_top
    import smls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [ROW_W-1:0]        row,
    input  logic [COL_W-1:0]        col,
    input  logic [LINE_W-1:0]       limit_lines,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [LINE_W-1:0]       row_drive,
    output logic [LINE_W-1:0]       col_drive,
    output logic [2:0]              motor_status,
    output logic                    start_accepted,
    output logic [1:0]              alarm,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CNT_W-1:0]        cfg_data
);

    logic [CNT_W-1:0] settle_delay_reg;
    logic [CNT_W-1:0] run_timeout_reg;

    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_reg;
    result_t  result;
    logic     in_accept;

    // input held off only while an untaken result sits in the register
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_delay_reg <= SETTLE_RESET;
            run_timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SETTLE:  settle_delay_reg <= cfg_data;
                REG_TIMEOUT: run_timeout_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    smls_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_accept),
        .func         (func),
        .row          (row),
        .col          (col),
        .limit_lines  (limit_lines),
        .settle_delay (settle_delay_reg),
        .run_timeout  (run_timeout_reg),
        .result       (result)
    );

    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_reg <= result;
    end

    assign out_valid      = out_valid_reg;
    assign row_drive      = out_reg.row_drive;
    assign col_drive      = out_reg.col_drive;
    assign motor_status   = out_reg.motor_status;
    assign start_accepted = out_reg.start_accepted;
    assign alarm          = out_reg.alarm;

endmodule

### rtl/smls_checker.sv
// Port-level assertions for the slot motor limit sequencer, bound to the top level.
// Depends on smls_pkg and slot_motor_limit_sequencer_top_macros.svh.
`include "slot_motor_limit_sequencer_top_macros.svh"

module smls_checker
    import smls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [LINE_W-1:0]   row_drive,
    input  logic [LINE_W-1:0]   col_drive,
    input  logic [2:0]          motor_status,
    input  logic                start_accepted,
    input  logic [1:0]          alarm
);

    `SMLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(row_drive) && $stable(col_drive) && $stable(motor_status) && $stable(alarm), "stalled result beat changed")
    `SMLS_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")
    `SMLS_ASSERT_NOW(a_drive_onehot, out_valid, $onehot0(row_drive) && $onehot0(col_drive), "drive lines not one-hot")
    `SMLS_ASSERT_NOW(a_col_needs_run, out_valid && col_drive != '0, row_drive != '0 && motor_status == PH_RUN, "column driven outside running")
    `SMLS_ASSERT_NOW(a_start_prep, out_valid && start_accepted, motor_status == PH_PREP && alarm == AL_NONE, "taken start not in prepare")

endmodule

bind slot_motor_limit_sequencer_top smls_checker u_smls_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .row_drive      (row_drive),
    .col_drive      (col_drive),
    .motor_status   (motor_status),
    .start_accepted (start_accepted),
    .alarm          (alarm)
);

### dv/tb_slot_motor_limit_sequencer_top.sv
// Self-checking testbench for slot_motor_limit_sequencer_top: start, tick and config traffic,
// each result beat compared against an in-bench motor sequencer predictor.
// Depends on smls_pkg and the RTL of slot_motor_limit_sequencer_top only.
module tb_slot_motor_limit_sequencer_top
    import smls_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat moving on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 3000;

    // Register indexes with no register behind them; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 func = 1'b0;
    logic [ROW_W-1:0]     row = '0;
    logic [COL_W-1:0]     col = '0;
    logic [LINE_W-1:0]    limit_lines = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [LINE_W-1:0]    row_drive;
    logic [LINE_W-1:0]    col_drive;
    logic [2:0]           motor_status;
    logic                 start_accepted;
    logic [1:0]           alarm;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    // Idle percentages for the sender and the receiver, changed per test phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Results predicted for accepted beats, oldest first.
    result_t motor_results_due[$];

    // Predictor copy of the sequencer state and its two registers.
    logic [CNT_W-1:0] settle_cfg = SETTLE_RESET;
    logic [CNT_W-1:0] run_cfg    = TIMEOUT_RESET;
    phase_t           mot_phase  = PH_IDLE;
    logic [ROW_W-1:0] sel_row    = '0;
    logic [COL_W-1:0] sel_col    = '0;
    logic [CNT_W-1:0] settle_left = '0;
    logic             settle_on  = 1'b0;
    logic [CNT_W-1:0] run_left   = '0;
    logic             run_on     = 1'b0;
    prior_t           last_limit = PL_UNKNOWN;

    slot_motor_limit_sequencer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .row            (row),
        .col            (col),
        .limit_lines    (limit_lines),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_drive      (row_drive),
        .col_drive      (col_drive),
        .motor_status   (motor_status),
        .start_accepted (start_accepted),
        .alarm          (alarm),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Any stop drops both drive lines, disarms both timers and forgets the limit history.
    function automatic void halt_motor(phase_t next_phase);
        sel_row     = '0;
        sel_col     = '0;
        settle_on   = 1'b0;
        settle_left = '0;
        run_on      = 1'b0;
        run_left    = '0;
        last_limit  = PL_UNKNOWN;
        mot_phase   = next_phase;
    endfunction

    function automatic result_t predict_motor_beat(func_t fn, logic [ROW_W-1:0] r,
                                                   logic [COL_W-1:0] c,
                                                   logic [LINE_W-1:0] lines);
        result_t res;
        logic    settle_done;
        logic    now_high;
        res = '0;
        settle_done = 1'b0;
        if (fn == FN_START)
        begin
            // channel range is checked before the busy state
            if (r >= ROWS || c >= COLS)
                res.alarm = AL_CHANNEL;
            else if (mot_phase == PH_RUN || mot_phase == PH_PREP)
                res.alarm = AL_CONFLICT;
            else
            begin
                sel_row     = r;
                sel_col     = c;
                mot_phase   = PH_PREP;
                settle_left = settle_cfg;
                settle_on   = 1'b1;
                run_on      = 1'b0;
                run_left    = '0;
                last_limit  = PL_UNKNOWN;
                res.start_accepted = 1'b1;
            end
        end
        else
        begin
            if (settle_on)
            begin
                // a count of zero expires on the first tick, as one does
                if (settle_left <= 1)
                begin
                    settle_left = '0;
                    settle_on   = 1'b0;
                    settle_done = 1'b1;
                    if (lines[sel_row])
                    begin
                        mot_phase  = PH_RUN;
                        run_left   = run_cfg;
                        run_on     = 1'b1;
                        last_limit = PL_UNKNOWN;
                    end
                    else
                        halt_motor(PH_LIMERR);
                end
                else
                    settle_left = settle_left - 1'b1;
            end
            // the settle expiry tick does nothing further
            if (!settle_done)
            begin
                if (mot_phase == PH_RUN)
                begin
                    now_high = lines[sel_row];
                    if (last_limit == PL_LOW && now_high)
                        halt_motor(PH_IDLE);
                    else
                        last_limit = now_high ? PL_HIGH : PL_LOW;
                end
                // an edge stop has already disarmed the timeout
                if (run_on)
                begin
                    if (run_left <= 1)
                    begin
                        halt_motor(PH_TIMEOUT);
                        res.alarm = AL_CHANNEL;
                    end
                    else
                        run_left = run_left - 1'b1;
                end
            end
        end
        res.motor_status = mot_phase;
        if (mot_phase == PH_PREP || mot_phase == PH_RUN)
            res.row_drive = LINE_W'(1) << sel_row;
        if (mot_phase == PH_RUN)
            res.col_drive = LINE_W'(1) << sel_col;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Sends one beat and books its prediction once the sequencer takes it. Valid is left
    // high so the next call can follow on straight away; drain_results lowers it.
    task automatic send_beat(func_t fn, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                             logic [LINE_W-1:0] lines);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= fn;
        row         <= r;
        col         <= c;
        limit_lines <= lines;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        motor_results_due.push_back(predict_motor_beat(fn, r, c, lines));
    endtask

    // Holds the sender off until every booked result has come back, then lets the
    // pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (motor_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Leaves cfg_valid high for back-to-back writes; release_cfg drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_SETTLE)
            settle_cfg = val;
        else if (idx == REG_TIMEOUT)
            run_cfg = val;
    endtask

    task automatic release_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(logic [CNT_W-1:0] settle, logic [CNT_W-1:0] timeout);
        drain_results();
        write_reg(REG_SETTLE, settle);
        write_reg(REG_TIMEOUT, timeout);
        release_cfg();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (motor_results_due.size() == 0)
                report_mismatch("result beat with nothing due", int'(motor_status), -1);
            else
            begin
                want = motor_results_due.pop_front();
                if (row_drive !== want.row_drive)
                    report_mismatch("row_drive", int'(row_drive), int'(want.row_drive));
                if (col_drive !== want.col_drive)
                    report_mismatch("col_drive", int'(col_drive), int'(want.col_drive));
                if (motor_status !== want.motor_status)
                    report_mismatch("motor_status", int'(motor_status),
                                    int'(want.motor_status));
                if (start_accepted !== want.start_accepted)
                    report_mismatch("start_accepted", int'(start_accepted),
                                    int'(want.start_accepted));
                if (alarm !== want.alarm)
                    report_mismatch("alarm", int'(alarm), int'(want.alarm));
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Any beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", quiet_cycles);
            $display("FAIL slot_motor_limit_sequencer_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register reset values: a start under the default settle delay must only reach
    // running on the 500th tick, and the default timeout must not fire soon after.
    task automatic test_reset_values();
        logic [LINE_W-1:0] lines;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(FN_START, 4'd3, 4'd7, LINE_W'($urandom_range(1023)));
        for (int i = 0; i < 500; i++)
        begin
            lines = LINE_W'($urandom_range(1023));
            if (i == 499)
                lines[3] = 1'b1;
            send_beat(FN_TICK, ROW_W'($urandom_range(15)), COL_W'($urandom_range(15)), lines);
        end
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h3F7);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h008);
        drain_results();
    endtask

    // Hand-picked beats: range checks, busy checks, every stop route, restarts.
    task automatic test_directed_cases();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        set_timing(16'd1, 16'd3);
        send_beat(FN_START, 4'd10, 4'd0, '0);    // row just past the last
        send_beat(FN_START, 4'd15, 4'd15, '1);   // both fields at their top
        send_beat(FN_START, 4'd0, 4'd10, '0);    // column just past the last
        send_beat(FN_TICK, 4'd15, 4'd15, '1);    // tick while idle
        send_beat(FN_START, 4'd9, 4'd9, '0);     // taken, prepare
        send_beat(FN_START, 4'd0, 4'd0, '0);     // busy in prepare
        send_beat(FN_START, 4'd12, 4'd3, '0);    // range check wins over busy
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h200); // settle expiry, switch on: running
        send_beat(FN_START, 4'd1, 4'd1, '0);     // busy while running
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h000); // switch seen low
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h200); // rising edge: back to idle
        send_beat(FN_START, 4'd0, 4'd0, '1);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h3FE); // switch off at expiry: limit error
        send_beat(FN_START, 4'd0, 4'd9, '0);     // restart after limit error
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h001); // running
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h001); // held high, no edge
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h3FF);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h001); // timeout stop with alarm
        send_beat(FN_START, 4'd5, 4'd5, '0);     // restart after timeout
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h020);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h3DF);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h000);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h020); // edge on the timeout tick: edge wins
        drain_results();
    endtask

    // Zero in either register expires on the first tick.
    task automatic test_zero_counts();
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        set_timing(16'd0, 16'd0);
        send_beat(FN_START, 4'd9, 4'd0, '0);
        send_beat(FN_TICK, 4'd0, 4'd0, '1);
        send_beat(FN_TICK, 4'd0, 4'd0, '1);
        send_beat(FN_START, 4'd2, 4'd2, '1);
        send_beat(FN_TICK, 4'd0, 4'd0, '0);
        drain_results();
    endtask

    // Mostly short delays, sometimes zero or a few dozen ticks.
    function automatic logic [CNT_W-1:0] pick_ticks(int top);
        int k;
        k = $urandom_range(99);
        if (k < 10)
            return '0;
        else if (k < 20)
            return CNT_W'(1);
        else if (k < 28)
            return CNT_W'($urandom_range(40, 20));
        return CNT_W'($urandom_range(top, 2));
    endfunction

    task automatic run_random_beats(int count);
        logic              busy;
        int                k;
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        logic [LINE_W-1:0] lines;
        for (int i = 0; i < count; i++)
        begin
            // now and then hold the sender until everything is back
            if ($urandom_range(99) < 2)
                drain_results();
            busy  = (mot_phase == PH_PREP || mot_phase == PH_RUN);
            k     = $urandom_range(99);
            lines = LINE_W'($urandom_range(1023));
            r     = ROW_W'($urandom_range(ROWS - 1));
            c     = COL_W'($urandom_range(COLS - 1));
            if ((!busy && k < 55) || (busy && k < 4))
                send_beat(FN_START, r, c, lines);
            else if ((!busy && k < 65) || (busy && k < 8))
                send_beat(FN_START, ROW_W'($urandom_range(15)), COL_W'($urandom_range(15)),
                          lines);
            else
            begin
                // bias the selected switch so most starts reach running and then stop
                if (busy)
                    lines[sel_row] = ($urandom_range(99) < (mot_phase == PH_PREP ? 85 : 45));
                send_beat(FN_TICK, ROW_W'($urandom_range(15)), COL_W'($urandom_range(15)),
                          lines);
            end
        end
    endtask

    // Random sequences under each idling pattern, two timing settings per pattern.
    task automatic test_random_traffic();
        int send_mode[4] = '{0, 72, 0, 19};
        int recv_mode[4] = '{0, 0, 72, 19};
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct  = send_mode[m];
            recv_stall_pct = recv_mode[m];
            for (int s = 0; s < 2; s++)
            begin
                set_timing(pick_ticks(6), pick_ticks(12));
                run_random_beats(140);
            end
        end
        drain_results();
    endtask

    // Largest register values and writes to unused indexes. Runs last, since a
    // 65535-tick settle leaves the motor in prepare for the rest of the run.
    task automatic test_register_extremes();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        set_timing(16'd1, 16'hFFFF);
        send_beat(FN_START, 4'd4, 4'd8, '0);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h010);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h3EF);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h010);
        drain_results();
        // spare indexes must leave both registers as they are
        write_reg(REG_SPARE_A, CNT_W'($urandom_range(65535)));
        write_reg(REG_SPARE_B, 16'hFFFF);
        release_cfg();
        send_beat(FN_START, 4'd4, 4'd1, '0);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h010);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h000);
        send_beat(FN_TICK, 4'd0, 4'd0, 10'h010);
        set_timing(16'hFFFF, 16'hFFFF);
        send_beat(FN_START, 4'd7, 4'd2, '0);
        for (int i = 0; i < 5; i++)
            send_beat(FN_TICK, 4'd0, 4'd0, LINE_W'($urandom_range(1023)));
        send_beat(FN_START, 4'd7, 4'd2, '1);
        send_beat(FN_START, 4'd3, 4'd11, '0);
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_cases();
        test_zero_counts();
        test_random_traffic();
        test_register_extremes();

        drain_results();
        repeat (8) @(posedge clk);
        if (motor_results_due.size() != 0)
            report_mismatch("results never delivered", motor_results_due.size(), 0);
        if (mismatch_count == 0)
            $display("PASS slot_motor_limit_sequencer_top");
        else
            $display("FAIL slot_motor_limit_sequencer_top");
        $finish;
    end

endmodule

### slot_motor_limit_sequencer_top.f
+incdir+rtl
rtl/smls_pkg.sv
rtl/smls_ctrl.sv
rtl/slot_motor_limit_sequencer_top.sv
rtl/smls_checker.sv
dv/tb_slot_motor_limit_sequencer_top.sv
